// ----- sv/swrpm_pkg.sv -----
// Shared constants, types and helpers of the sliding-window RMS and peak meter.
// No dependencies; every other file but swrpm_ram imports this package.
package swrpm_pkg;

  localparam int WINDOW      = 44100;
  localparam int SAMPLE_BITS = 16;
  localparam int OUT_W       = 16;

  localparam int ADDR_W = $clog2(WINDOW);
  localparam int MAG_W  = SAMPLE_BITS + 1;
  localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W  = 2 * SAMPLE_BITS - 2 + $clog2(WINDOW + 1);
  localparam int ROOT_W = SAMPLE_BITS;
  localparam int TSQ_W  = 2 * ROOT_W;
  localparam int TEST_W = TSQ_W + $clog2(WINDOW + 1);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW - 1);
  localparam logic [ROOT_W-1:0] ROOT_TOP  = {1'b1, {(ROOT_W-1){1'b0}}};
  localparam logic [TEST_W-1:0] WINDOW_T  = TEST_W'(WINDOW);

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_ACC,
    ST_SCAN,
    ST_SCAN_END,
    ST_ROOT_SQ,
    ST_ROOT_TEST,
    ST_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic push_start;
    logic push_square;
    logic push_accum;
    logic scan_start;
    logic scan_read;
    logic root_init;
    logic root_square;
    logic root_test;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic root_last;
  } stat_t;

  // Magnitude of a two's complement sample; full-scale negative gives 2^(SAMPLE_BITS-1).
  function automatic logic [MAG_W-1:0] mag_f(input logic [SAMPLE_BITS-1:0] s);
    logic [MAG_W-1:0] ext;
    ext = {s[SAMPLE_BITS-1], s};
    return ext[MAG_W-1] ? (~ext + 1'b1) : ext;
  endfunction

endpackage

// ----- sv/swrpm_if.sv -----
// Valid/ready channel interfaces for sample requests and level results.
// Depends on swrpm_pkg.
interface swrpm_in_if;
  import swrpm_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  modport source (output valid, output operation, output sample_value, input ready);
  modport sink   (input valid, input operation, input sample_value, output ready);
endinterface

interface swrpm_out_if;
  import swrpm_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] rms_level;
  logic [OUT_W-1:0] peak_level;
  modport source (output valid, output rms_level, output peak_level, input ready);
  modport sink   (input valid, input rms_level, input peak_level, output ready);
endinterface

// ----- sv/sliding_window_rms_peak_meter_unit.sv -----
// Sliding-window RMS and peak level meter, top level. Depends on swrpm_pkg, swrpm_if,
// swrpm_ctrl, swrpm_dp. A push request runs store read, squares and sum update in turn.
// A report runs the peak scan through the single store read port, then the square-root
// search of 16 root bits, each a square step followed by a test step.
// Reset (rst_n low, synchronous) clears pointer, wrap flag and sum; never-written slots read
// as zero through the wrap flag, so the store needs no clearing pass.
module sliding_window_rms_peak_meter_unit (
  input logic        clk,
  input logic        rst_n,
  swrpm_in_if.sink   in_req,
  swrpm_out_if.source out_res
);
  import swrpm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence the requests: pushes and reports are taken only between jobs, while a
  // finished result may still sit in the output register.
  swrpm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_req.valid),
    .in_operation (in_req.operation),
    .in_ready     (in_req.ready),
    .out_valid    (out_res.valid),
    .out_ready    (out_res.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Hold the window, the exact sum of squares and the arithmetic units.
  swrpm_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .sample_value (in_req.sample_value),
    .rms_level    (out_res.rms_level),
    .peak_level   (out_res.peak_level)
  );

endmodule

// ----- sv/swrpm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module swrpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/swrpm_ctrl.sv -----
// Controller of the level meter: sequences push, scan and square-root search.
// Depends on swrpm_pkg; drives swrpm_dp through cmd_t and reads stat_t.
module swrpm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_operation,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  swrpm_pkg::stat_t  stat,
  output swrpm_pkg::cmd_t   cmd
);
  import swrpm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_operation == OP_PUSH) ? ST_PUSH_RD : ST_SCAN;
        end
      end
      ST_PUSH_RD:   state_nxt = ST_PUSH_ACC;
      ST_PUSH_ACC:  state_nxt = ST_IDLE;
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END:  state_nxt = ST_ROOT_SQ;
      ST_ROOT_SQ:   state_nxt = ST_ROOT_TEST;
      ST_ROOT_TEST: state_nxt = stat.root_last ? ST_OUT_WAIT : ST_ROOT_SQ;
      ST_OUT_WAIT: begin
        // hold until the output register frees
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.push_start = (in_operation == OP_PUSH);
          cmd.scan_start = (in_operation == OP_REPORT);
        end
      end
      ST_PUSH_RD:   cmd.push_square = 1'b1;
      ST_PUSH_ACC:  cmd.push_accum  = 1'b1;
      ST_SCAN:      cmd.scan_read   = 1'b1;
      ST_SCAN_END:  cmd.root_init   = 1'b1;
      ST_ROOT_SQ:   cmd.root_square = 1'b1;
      ST_ROOT_TEST: cmd.root_test   = 1'b1;
      ST_OUT_WAIT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/swrpm_dp.sv -----
// Datapath of the level meter: sample store, sum of squares, peak scan and
// bit-by-bit square-root search of the mean. Depends on swrpm_pkg, swrpm_ram.
module swrpm_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  swrpm_pkg::cmd_t                     cmd,
  output swrpm_pkg::stat_t                    stat,
  input  logic [swrpm_pkg::SAMPLE_BITS-1:0]   sample_value,
  output logic [swrpm_pkg::OUT_W-1:0]         rms_level,
  output logic [swrpm_pkg::OUT_W-1:0]         peak_level
);
  import swrpm_pkg::*;

  logic [ADDR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic                   full_r, full_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SQ_W-1:0]        old_sq_r, new_sq_r;
  logic [ADDR_W-1:0]      scan_addr_r;
  logic                   live_r, ent_ok_r;
  logic [MAG_W-1:0]       peak_r, cand;
  logic [ROOT_W-1:0]      root_r, bit_r;
  logic [TSQ_W-1:0]       tsq_r;
  logic [OUT_W-1:0]       rms_out_r, peak_out_r;

  logic [SAMPLE_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   rd_en;
  logic [MAG_W-1:0]       old_mag, new_mag;
  logic [2*MAG_W-1:0]     old_prod, new_prod;
  logic [ROOT_W-1:0]      trial;
  logic [TSQ_W-1:0]       trial_sq;
  logic                   root_fit;

  assign rd_en   = cmd.push_start || cmd.scan_read;
  assign rd_addr = cmd.scan_read ? scan_addr_r : wr_ptr_r;

  swrpm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW)) u_store (
    .clk   (clk),
    .we    (cmd.push_square),
    .waddr (wr_ptr_r),
    .wdata (sample_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // slots past the write pointer were never written until the first wrap: read them as zero
  assign old_mag  = full_r ? mag_f(rd_data) : '0;
  assign new_mag  = mag_f(sample_r);
  assign old_prod = (2*MAG_W)'(old_mag) * (2*MAG_W)'(old_mag);
  assign new_prod = (2*MAG_W)'(new_mag) * (2*MAG_W)'(new_mag);
  assign cand     = ent_ok_r ? mag_f(rd_data) : '0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    full_nxt   = full_r;
    sum_nxt    = sum_r;
    if (cmd.push_accum) begin
      sum_nxt = sum_r - SUM_W'(old_sq_r) + SUM_W'(new_sq_r);
      if (wr_ptr_r == LAST_ADDR) begin
        wr_ptr_nxt = '0;
        full_nxt   = 1'b1;
      end else begin
        wr_ptr_nxt = wr_ptr_r + 1'b1;
      end
    end
  end

  // the floored root of the floored mean is the largest r with r*r*WINDOW <= sum
  assign trial    = root_r | bit_r;
  assign trial_sq = TSQ_W'(trial) * TSQ_W'(trial);
  assign root_fit = (TEST_W'(tsq_r) * WINDOW_T) <= TEST_W'(sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      full_r   <= 1'b0;
      sum_r    <= '0;
      live_r   <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      full_r   <= full_nxt;
      sum_r    <= sum_nxt;
      live_r   <= cmd.scan_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_start) begin
      sample_r <= sample_value;
    end
    if (cmd.push_square) begin
      old_sq_r <= old_prod[SQ_W-1:0];
      new_sq_r <= new_prod[SQ_W-1:0];
    end

    if (cmd.scan_start) begin
      scan_addr_r <= '0;
    end else if (cmd.scan_read) begin
      scan_addr_r <= scan_addr_r + 1'b1;
    end
    if (cmd.scan_read) begin
      ent_ok_r <= full_r || (scan_addr_r < wr_ptr_r);
    end
    if (cmd.scan_start) begin
      peak_r <= '0;
    end else if (live_r && (cand > peak_r)) begin
      peak_r <= cand;
    end

    if (cmd.root_init) begin
      root_r <= '0;
      bit_r  <= ROOT_TOP;
    end else if (cmd.root_test) begin
      if (root_fit) begin
        root_r <= trial;
      end
      bit_r <= bit_r >> 1;
    end
    if (cmd.root_square) begin
      tsq_r <= trial_sq;
    end

    if (cmd.out_load) begin
      rms_out_r  <= OUT_W'(root_r);
      peak_out_r <= OUT_W'(peak_r);
    end
  end

  assign stat.scan_last = (scan_addr_r == LAST_ADDR);
  assign stat.root_last = bit_r[0];

  assign rms_level  = rms_out_r;
  assign peak_level = peak_out_r;

endmodule

// ----- tb/sliding_window_rms_peak_meter_unit_tb.sv -----
// Self-checking testbench for the sliding-window RMS and peak level meter.
// Depends on swrpm_pkg, swrpm_if and the sliding_window_rms_peak_meter_unit RTL.
`timescale 1ns / 100ps

module sliding_window_rms_peak_meter_unit_tb;
  import swrpm_pkg::*;

  // A report waits on the full store scan plus the root search.
  localparam int REPORT_CYC = WINDOW + 34;
  // Receiver hold-off long enough to leave a finished report waiting.
  localparam int HOLD_CYC   = REPORT_CYC + 400;
  // Cycles to let a trailing push retire after the last result.
  localparam int DRAIN_CYC  = 16;
  // Samples written per pass of the partial-fill test.
  localparam int FILL_CNT   = 64;

  typedef struct {
    logic [OUT_W-1:0] rms;
    logic [OUT_W-1:0] peak;
  } level_t;

  logic clk;
  logic rst_n;

  swrpm_in_if  in_req ();
  swrpm_out_if out_res ();

  sliding_window_rms_peak_meter_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  // Shadow copy of the window, its write slot and the running sum of squares.
  logic signed [SAMPLE_BITS-1:0] window_shadow [WINDOW];
  int unsigned                   shadow_slot;
  logic [63:0]                   shadow_sq_sum;

  level_t pending_levels[$];
  int     mismatch_count;
  bit     idle_on;
  int     hold_seq;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #250_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [63:0] sample_mag(input logic signed [SAMPLE_BITS-1:0] s);
    int v;
    v = s;
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [OUT_W-1:0] floor_root(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r[OUT_W-1:0];
  endfunction

  // Displace the oldest sample and keep the sum of squares exact.
  task automatic shadow_push(input logic signed [SAMPLE_BITS-1:0] s);
    logic [63:0] old_mag;
    logic [63:0] new_mag;
    old_mag = sample_mag(window_shadow[shadow_slot]);
    new_mag = sample_mag(s);
    shadow_sq_sum = shadow_sq_sum - old_mag * old_mag + new_mag * new_mag;
    window_shadow[shadow_slot] = s;
    shadow_slot = (shadow_slot == WINDOW - 1) ? 0 : shadow_slot + 1;
  endtask

  function automatic level_t predict_levels();
    level_t      lv;
    logic [63:0] pk;
    logic [63:0] m;
    pk = '0;
    for (int i = 0; i < WINDOW; i++) begin
      m = sample_mag(window_shadow[i]);
      if (m > pk) pk = m;
    end
    lv.rms  = floor_root(shadow_sq_sum / 64'(WINDOW));
    lv.peak = pk[OUT_W-1:0];
    return lv;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input logic op, input logic signed [SAMPLE_BITS-1:0] s);
    in_req.valid        <= 1'b1;
    in_req.operation    <= op;
    in_req.sample_value <= s;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    if (op == OP_REPORT) pending_levels.insert(pending_levels.size(), predict_levels());
    else shadow_push(s);
  endtask

  task automatic idle_gap(input int n);
    in_req.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Insert a random idle burst before a request when idling is enabled.
  task automatic paced_request(input logic op, input logic signed [SAMPLE_BITS-1:0] s);
    if (idle_on && $urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 18));
    send_request(op, s);
  endtask

  task automatic wait_drain();
    in_req.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    int stall_left;
    int hold_left;
    int hold_seen;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_res.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_res.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expected level pair.
  always @(posedge clk) begin
    level_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_levels.size() == 0) begin
        if (mismatch_count < 10)
          $display("mismatch: unexpected result rms=%0d peak=%0d",
                   out_res.rms_level, out_res.peak_level);
        mismatch_count++;
      end else begin
        want = pending_levels.pop_front();
        if (want.rms !== out_res.rms_level || want.peak !== out_res.peak_level) begin
          if (mismatch_count < 10)
            $display("mismatch: rms exp=%0d act=%0d, peak exp=%0d act=%0d",
                     want.rms, out_res.rms_level, want.peak, out_res.peak_level);
          mismatch_count++;
        end
      end
    end
  end

  // Reports on the zeroed window; the sample field must be ignored.
  task automatic test_empty_window();
    paced_request(OP_REPORT, 16'sh0000);
    paced_request(OP_REPORT, 16'sh7FFF);
    wait_drain();
  endtask

  // Full-scale values and alternating bit patterns, with a partly filled window.
  task automatic test_field_extremes();
    paced_request(OP_PUSH, 16'sh8000);
    paced_request(OP_REPORT, 16'sh8000);
    paced_request(OP_PUSH, 16'sh7FFF);
    paced_request(OP_PUSH, 16'sh0000);
    paced_request(OP_PUSH, 16'shFFFF);
    paced_request(OP_PUSH, 16'sh0001);
    paced_request(OP_PUSH, 16'sh5555);
    paced_request(OP_PUSH, 16'shAAAA);
    paced_request(OP_REPORT, 16'shAAAA);
    paced_request(OP_PUSH, 16'sh8001);
    paced_request(OP_REPORT, 16'sh5555);
    wait_drain();
  endtask

  // Back-to-back full-scale negatives, then a paced run of moderate samples.
  task automatic test_partial_fill();
    idle_on = 1'b0;
    for (int i = 0; i < FILL_CNT; i++) send_request(OP_PUSH, 16'sh8000);
    send_request(OP_REPORT, 16'sh0000);
    wait_drain();
    idle_on = 1'b1;
    for (int i = 0; i < FILL_CNT; i++)
      paced_request(OP_PUSH, SAMPLE_BITS'(int'($urandom_range(0, 6000)) - 3000));
    paced_request(OP_REPORT, 16'sh0000);
    wait_drain();
  endtask

  // Hold the result side off so a finished report stalls the input.
  task automatic test_input_backpressure();
    hold_seq++;
    send_request(OP_REPORT, 16'sh1234);
    for (int i = 0; i < 40; i++) send_request(OP_PUSH, rand_sample());
    send_request(OP_REPORT, 16'sh0000);
    for (int i = 0; i < 10; i++) send_request(OP_PUSH, rand_sample());
    wait_drain();
  endtask

  task automatic test_random_stream(input int min_items, input int min_reports,
                                    input int report_odds);
    int n;
    int reports;
    n       = 0;
    reports = 0;
    while (n < min_items || reports < min_reports) begin
      if ($urandom_range(1, report_odds) == 1) begin
        paced_request(OP_REPORT, SAMPLE_BITS'($urandom()));
        reports++;
      end else begin
        paced_request(OP_PUSH, rand_sample());
      end
      n++;
    end
    wait_drain();
  endtask

  initial begin
    mismatch_count = 0;
    hold_seq       = 0;
    idle_on        = 1'b1;
    shadow_slot    = 0;
    shadow_sq_sum  = '0;
    for (int i = 0; i < WINDOW; i++) window_shadow[i] = '0;
    rst_n               <= 1'b0;
    in_req.valid        <= 1'b0;
    in_req.operation    <= OP_PUSH;
    in_req.sample_value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_window();
    test_field_extremes();
    test_partial_fill();
    test_input_backpressure();
    test_random_stream(750, 14, 45);
    // Closing stretch runs with no idling on either side.
    idle_on = 1'b0;
    test_random_stream(110, 3, 35);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
